// ===== rtl/imuf_pkg.sv =====
// Shared constants, types and register codes for the IMU FIFO frame unpacker.
`default_nettype none

package imuf_pkg;

  localparam int OUT_WIDTH  = 32;
  localparam int OUT_TDATA_W = ((OUT_WIDTH + 7) / 8) * 8;

  localparam int CH_W       = 3;
  localparam int RAW_W      = 16;
  localparam int POS_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int QDEPTH = 2;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_BIAS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_RECIP  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFFSET = 3'd7;

  localparam logic [CH_W-1:0] CH_AX   = 3'd0;
  localparam logic [CH_W-1:0] CH_AZ   = 3'd2;
  localparam logic [CH_W-1:0] CH_TEMP = 3'd3;
  localparam logic [CH_W-1:0] CH_GX   = 3'd4;

  localparam logic [POS_W-1:0] ACCEL_BYTES = 4'd6;
  localparam logic [POS_W-1:0] GYRO_BYTES  = 4'd6;
  localparam logic [POS_W-1:0] TEMP_BYTES  = 4'd2;

  localparam int EN_ACCEL = 0;
  localparam int EN_GYRO  = 1;
  localparam int EN_TEMP  = 2;

  localparam logic [59:0] ACCEL_GAIN_RESET = 60'd72057662757470208;
  localparam logic [23:0] TEMP_RECIP_RESET = 24'd126640;
  localparam logic signed [31:0] TEMP_OFFSET_RESET = 32'sd1638400;

  typedef struct packed {
    logic [2:0]         enable_mask;
    logic [31:0]        accel_scale;
    logic [31:0]        gyro_scale;
    logic [59:0]        accel_bias;
    logic [59:0]        accel_gain;
    logic [59:0]        gyro_bias;
    logic [23:0]        temp_recip;
    logic signed [31:0] temp_offset;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [RAW_W-1:0] raw;
    logic             frame_end;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/imuf_front.sv =====
// Byte parser: tracks frame position, pairs bytes into samples and tags each with its channel.
`default_nettype none

module imuf_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [2:0]                     enable_mask,
  input  wire logic                           pos_clear,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           q_full,
  output logic                                q_push,
  output imuf_pkg::job_t                      q_job
);

  logic [imuf_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                 hold_r, hold_nxt;
  logic [imuf_pkg::POS_W-1:0] size;
  logic [imuf_pkg::POS_W-1:0] pos_cur;
  logic [imuf_pkg::POS_W-1:0] pos_inc;
  logic [2:0]                 idx;
  logic [2:0]                 idx2;
  logic [imuf_pkg::CH_W-1:0]  ch;
  logic                       accept;
  logic                       last;

  always_comb begin
    size = (enable_mask[imuf_pkg::EN_ACCEL] ? imuf_pkg::ACCEL_BYTES : '0) +
           (enable_mask[imuf_pkg::EN_GYRO]  ? imuf_pkg::GYRO_BYTES  : '0) +
           (enable_mask[imuf_pkg::EN_TEMP]  ? imuf_pkg::TEMP_BYTES  : '0);
    pos_cur = (pos_r >= size) ? '0 : pos_r;
    pos_inc = pos_cur + 4'd1;
    last    = (pos_inc == size);
    idx     = pos_cur[3:1];
    idx2    = enable_mask[imuf_pkg::EN_ACCEL] ? idx - 3'd3 : idx;
    if (enable_mask[imuf_pkg::EN_ACCEL] && (idx < 3'd3)) begin
      ch = idx;
    end else if (enable_mask[imuf_pkg::EN_TEMP] && (idx2 == 3'd0)) begin
      ch = imuf_pkg::CH_TEMP;
    end else begin
      ch = imuf_pkg::CH_GX + (enable_mask[imuf_pkg::EN_TEMP] ? idx2 - 3'd1 : idx2);
    end
  end

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept && (size != '0) && pos_cur[0];

  assign q_job.channel   = ch;
  assign q_job.raw       = {hold_r, in_byte};
  assign q_job.frame_end = last;

  always_comb begin
    pos_nxt  = pos_r;
    hold_nxt = hold_r;
    if (pos_clear) begin
      pos_nxt = '0;
    end else if (accept) begin
      if (size == '0) begin
        pos_nxt = '0;
      end else if (!pos_cur[0]) begin
        pos_nxt  = pos_inc;
        hold_nxt = in_byte;
      end else begin
        pos_nxt = last ? '0 : pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      hold_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      hold_r <= hold_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imuf_queue.sv =====
// Short sample queue between the byte parser and the calibration datapath.
`default_nettype none

module imuf_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire imuf_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output imuf_pkg::job_t      pop_job,
  output logic                empty
);

  imuf_pkg::job_t             slot_r [imuf_pkg::QDEPTH];
  logic [imuf_pkg::QAW-1:0]   wr_r, wr_nxt;
  logic [imuf_pkg::QAW-1:0]   rd_r, rd_nxt;
  logic [imuf_pkg::QCW-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == imuf_pkg::QCW'(imuf_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = slot_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == imuf_pkg::QAW'(imuf_pkg::QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == imuf_pkg::QAW'(imuf_pkg::QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= imuf_pkg::QCW'(imuf_pkg::QDEPTH))
    else $error("queue count past depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a push");

endmodule

`default_nettype wire

// ===== rtl/imuf_calc.sv =====
// Calibration datapath: scale, bias, gain, rounding and saturation, with output register.
`default_nettype none

module imuf_calc (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire imuf_pkg::cfg_t                    cfg,
  input  wire logic                              q_empty,
  input  wire imuf_pkg::job_t                    q_job,
  output logic                                   q_pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [imuf_pkg::OUT_WIDTH-1:0]         out_value,
  output logic [imuf_pkg::CH_W-1:0]              out_channel,
  output logic                                   out_last
);

  localparam int DW = imuf_pkg::RAW_W + 34;
  localparam int MW = DW - 1;
  localparam int HW = MW - 24 + 20;
  localparam int LW = 24 + 20;
  localparam int QW = HW + 1;
  localparam int VW = 49;
  localparam logic signed [VW-1:0] SAT_HI =
    VW'((65'sd1 <<< (imuf_pkg::OUT_WIDTH - 1)) - 65'sd1);
  localparam logic signed [VW-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MUL  = 9'b000000010,
    ST_SUB  = 9'b000000100,
    ST_ABS  = 9'b000001000,
    ST_MULH = 9'b000010000,
    ST_MULL = 9'b000100000,
    ST_SUM  = 9'b001000000,
    ST_SGN  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } calc_state_t;

  calc_state_t                  state_r, state_nxt;
  logic [imuf_pkg::CH_W-1:0]    ch_r;
  logic [imuf_pkg::RAW_W-1:0]   raw_r;
  logic                         end_r;
  logic signed [DW-1:0]         prod_r;
  logic signed [DW-1:0]         d_r;
  logic [MW-1:0]                m_r;
  logic                         neg_r;
  logic [HW-1:0]                hp_r;
  logic [LW-1:0]                lp_r;
  logic [QW-1:0]                q_r;
  logic signed [VW-1:0]         v_r;
  logic                         oval_r, oval_nxt;
  logic [imuf_pkg::OUT_WIDTH-1:0] oval_data_r;
  logic [imuf_pkg::CH_W-1:0]    och_r;
  logic                         olast_r;

  logic                         is_accel;
  logic                         is_temp;
  logic [1:0]                   axis;
  logic [31:0]                  mul_b;
  logic [19:0]                  bias20;
  logic [19:0]                  gain20;
  logic signed [imuf_pkg::RAW_W+32:0] p1;
  logic signed [DW-1:0]         bterm;
  logic [LW:0]                  rnd_l;
  logic [MW:0]                  rnd_m;
  logic [VW-1:0]                qv;
  logic signed [VW-1:0]         v_sgn;
  logic signed [VW-1:0]         v_sat;
  logic                         out_load;

  function automatic logic [19:0] field20(input logic [59:0] packed_v, input logic [1:0] ax);
    logic [19:0] f;
    case (ax)
      2'd0:    f = packed_v[19:0];
      2'd1:    f = packed_v[39:20];
      2'd2:    f = packed_v[59:40];
      default: f = '0;
    endcase
    return f;
  endfunction

  always_comb begin
    is_accel = (ch_r <= imuf_pkg::CH_AZ);
    is_temp  = (ch_r == imuf_pkg::CH_TEMP);
    axis     = is_accel ? ch_r[1:0] : 2'(ch_r - imuf_pkg::CH_GX);
    if (is_accel) begin
      mul_b  = cfg.accel_scale;
      bias20 = field20(cfg.accel_bias, axis);
    end else if (is_temp) begin
      mul_b  = {8'd0, cfg.temp_recip};
      bias20 = '0;
    end else begin
      mul_b  = cfg.gyro_scale;
      bias20 = field20(cfg.gyro_bias, axis);
    end
    gain20 = field20(cfg.accel_gain, axis);
    p1     = $signed(raw_r) * $signed({1'b0, mul_b});
    bterm  = {{(DW - 32){bias20[19]}}, bias20, 12'd0};
    rnd_l  = {1'b0, lp_r} + (LW + 1)'(24'h800000);
    rnd_m  = {1'b0, m_r} + (MW + 1)'(8'd128);
    qv     = VW'(q_r);
    v_sgn  = neg_r ? -$signed(qv) : $signed(qv);
    if (is_temp) begin
      v_sgn = v_sgn + VW'(cfg.temp_offset);
    end
    if (v_r > SAT_HI) begin
      v_sat = SAT_HI;
    end else if (v_r < SAT_LO) begin
      v_sat = SAT_LO;
    end else begin
      v_sat = v_r;
    end
  end

  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign out_load = (state_r == ST_OUT) && (!oval_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (!q_empty) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SUB;
      ST_SUB:  state_nxt = ST_ABS;
      ST_ABS:  state_nxt = is_accel ? ST_MULH : ST_SUM;
      ST_MULH: state_nxt = ST_MULL;
      ST_MULL: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_SGN;
      ST_SGN:  state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    oval_nxt = oval_r;
    if (oval_r && out_tready) begin
      oval_nxt = 1'b0;
    end
    if (out_load) begin
      oval_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ch_r  <= q_job.channel;
      raw_r <= q_job.raw;
      end_r <= q_job.frame_end;
    end
    if (state_r == ST_MUL) begin
      prod_r <= DW'(p1);
    end
    if (state_r == ST_SUB) begin
      d_r <= prod_r - bterm;
    end
    if (state_r == ST_ABS) begin
      neg_r <= d_r[DW-1];
      m_r   <= d_r[DW-1] ? MW'(-d_r) : MW'(d_r);
    end
    if (state_r == ST_MULH) begin
      hp_r <= m_r[MW-1:24] * gain20;
    end
    if (state_r == ST_MULL) begin
      lp_r <= m_r[23:0] * gain20;
    end
    if (state_r == ST_SUM) begin
      q_r <= is_accel ? QW'(hp_r) + QW'(rnd_l[LW:24]) : QW'(rnd_m[MW:8]);
    end
    if (state_r == ST_SGN) begin
      v_r <= v_sgn;
    end
    if (out_load) begin
      oval_data_r <= v_sat[imuf_pkg::OUT_WIDTH-1:0];
      och_r       <= ch_r;
      olast_r     <= end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

  assign out_tvalid  = oval_r;
  assign out_value   = oval_data_r;
  assign out_channel = och_r;
  assign out_last    = olast_r;

endmodule

`default_nettype wire

// ===== rtl/imu_fifo_frame_unpack_calibrate.sv =====
// Top level: configuration registers, byte parser, sample queue and calibration datapath.
`default_nettype none

// Takes the sensor FIFO stream one byte per item and emits one calibrated Q16.16 sample per
// completed big-endian int16 value, tagged with its channel (tuser) and the frame's last sample
// (tlast). The parser accepts a byte every cycle while its two-entry sample queue has room; the
// calibration datapath takes one sample at a time through multiply, bias, magnitude, sum and
// sign states (an accel sample adds a gain state for each of its two 20-bit gain products) and
// loads the output register before it pops the next sample; with one sample per two bytes, the
// sustained byte rate is set by the sequencer. Writing enable_mask restarts the frame position.
// Configuration is accepted every cycle and must be written only while the block is idle.
module imu_fifo_frame_unpack_calibrate (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,   // [7:0] fifo_byte
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [imuf_pkg::OUT_TDATA_W-1:0]         out_tdata,  // [OUT_WIDTH-1:0] sample_value
  output logic [imuf_pkg::CH_W-1:0]                out_tuser,  // [2:0] channel
  output logic                                     out_tlast,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [imuf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [imuf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  imuf_pkg::cfg_t  cfg_r, cfg_nxt;
  imuf_pkg::job_t  push_job;
  imuf_pkg::job_t  pop_job;
  logic            cfg_wr;
  logic            pos_clear;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  logic [imuf_pkg::OUT_WIDTH-1:0] out_value;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign pos_clear = cfg_wr && (cfg_index == imuf_pkg::REG_ENABLE_MASK);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_index)
        imuf_pkg::REG_ENABLE_MASK: cfg_nxt.enable_mask = cfg_data[2:0];
        imuf_pkg::REG_ACCEL_SCALE: cfg_nxt.accel_scale = cfg_data[31:0];
        imuf_pkg::REG_GYRO_SCALE:  cfg_nxt.gyro_scale  = cfg_data[31:0];
        imuf_pkg::REG_ACCEL_BIAS:  cfg_nxt.accel_bias  = cfg_data[59:0];
        imuf_pkg::REG_ACCEL_GAIN:  cfg_nxt.accel_gain  = cfg_data[59:0];
        imuf_pkg::REG_GYRO_BIAS:   cfg_nxt.gyro_bias   = cfg_data[59:0];
        imuf_pkg::REG_TEMP_RECIP:  cfg_nxt.temp_recip  = cfg_data[23:0];
        imuf_pkg::REG_TEMP_OFFSET: cfg_nxt.temp_offset = $signed(cfg_data[31:0]);
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_mask <= '0;
      cfg_r.accel_scale <= '0;
      cfg_r.gyro_scale  <= '0;
      cfg_r.accel_bias  <= '0;
      cfg_r.accel_gain  <= imuf_pkg::ACCEL_GAIN_RESET;
      cfg_r.gyro_bias   <= '0;
      cfg_r.temp_recip  <= imuf_pkg::TEMP_RECIP_RESET;
      cfg_r.temp_offset <= imuf_pkg::TEMP_OFFSET_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  imuf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .enable_mask (cfg_r.enable_mask),
    .pos_clear   (pos_clear),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_byte     (in_tdata),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  imuf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  imuf_calc u_calc (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_empty     (q_empty),
    .q_job       (pop_job),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_value   (out_value),
    .out_channel (out_tuser),
    .out_last    (out_tlast)
  );

  assign out_tdata = imuf_pkg::OUT_TDATA_W'(out_value);

endmodule

`default_nettype wire

// ===== test/imu_fifo_unpack_checker.sv =====
// Checker for the IMU FIFO unpacker: predicts each calibrated sample and compares it.
`timescale 1ns / 1ps

module imu_fifo_unpack_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [7:0]                       in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [imuf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [imuf_pkg::CH_W-1:0]        out_tuser,
  input  logic                             out_tlast,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [imuf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [imuf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               mismatches,
  output int                               samples_pending,
  output int                               samples_compared
);

  typedef struct packed {
    logic [imuf_pkg::CH_W-1:0]      channel;
    logic [imuf_pkg::OUT_WIDTH-1:0] value;
    logic                           frame_end;
  } sample_t;

  imuf_pkg::cfg_t regs;
  logic [3:0]     byte_pos;
  logic [7:0]     high_hold;
  sample_t        expected_samples[$];
  int             errors = 0;
  int             compared = 0;

  function automatic longint round_away(longint v, int sh);
    logic [63:0] m;
    if (v < 0) m = -v;
    else m = v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [imuf_pkg::OUT_WIDTH-1:0] clamp_q16(longint v);
    longint hi_lim;
    longint lo_lim;
    hi_lim = (longint'(1) <<< (imuf_pkg::OUT_WIDTH - 1)) - 1;
    lo_lim = -hi_lim - 1;
    if (v > hi_lim) v = hi_lim;
    else if (v < lo_lim) v = lo_lim;
    return v[imuf_pkg::OUT_WIDTH-1:0];
  endfunction

  function automatic longint scaled_minus_bias(logic signed [15:0] raw, logic [31:0] scale,
                                               logic [59:0] biases, int axis);
    logic signed [19:0] b;
    b = biases[axis*20 +: 20];
    return longint'(raw) * longint'({32'd0, scale}) - longint'(b) * 64'sd4096;
  endfunction

  function automatic longint accel_q16(logic signed [15:0] raw, int axis);
    longint      d;
    logic [63:0] m;
    logic [63:0] g;
    logic [63:0] q;
    d = scaled_minus_bias(raw, regs.accel_scale, regs.accel_bias, axis);
    g = 64'(regs.accel_gain[axis*20 +: 20]);
    if (d < 0) m = -d;
    else m = d;
    q = (m >> 24) * g + (((m & 64'hFF_FFFF) * g + 64'h80_0000) >> 24);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint gyro_q16(logic signed [15:0] raw, int axis);
    return round_away(scaled_minus_bias(raw, regs.gyro_scale, regs.gyro_bias, axis), 8);
  endfunction

  function automatic longint temp_q16(logic signed [15:0] raw);
    return round_away(longint'(raw) * longint'({40'd0, regs.temp_recip}), 8) +
           longint'(signed'(regs.temp_offset));
  endfunction

  task automatic unpack_byte(logic [7:0] b);
    logic [3:0]                size;
    logic [3:0]                p;
    logic [2:0]                idx;
    logic [imuf_pkg::CH_W-1:0] ch;
    logic signed [15:0]        raw;
    longint                    v;
    sample_t                   s;
    size = (regs.enable_mask[imuf_pkg::EN_ACCEL] ? imuf_pkg::ACCEL_BYTES : 4'd0) +
           (regs.enable_mask[imuf_pkg::EN_GYRO]  ? imuf_pkg::GYRO_BYTES  : 4'd0) +
           (regs.enable_mask[imuf_pkg::EN_TEMP]  ? imuf_pkg::TEMP_BYTES  : 4'd0);
    if (size == 0) begin
      byte_pos = '0;
      return;
    end
    p = (byte_pos >= size) ? 4'd0 : byte_pos;
    if (!p[0]) begin
      high_hold = b;
      byte_pos  = p + 4'd1;
      return;
    end
    raw = {high_hold, b};
    idx = 3'(p >> 1);
    if (regs.enable_mask[imuf_pkg::EN_ACCEL] && idx < 3) begin
      ch = imuf_pkg::CH_AX + idx;
      v  = accel_q16(raw, idx);
    end else begin
      if (regs.enable_mask[imuf_pkg::EN_ACCEL]) idx = idx - 3'd3;
      if (regs.enable_mask[imuf_pkg::EN_TEMP] && idx == 0) begin
        ch = imuf_pkg::CH_TEMP;
        v  = temp_q16(raw);
      end else begin
        if (regs.enable_mask[imuf_pkg::EN_TEMP]) idx = idx - 3'd1;
        ch = imuf_pkg::CH_GX + idx;
        v  = gyro_q16(raw, idx);
      end
    end
    p           = p + 4'd1;
    s.channel   = ch;
    s.value     = clamp_q16(v);
    s.frame_end = (p == size);
    byte_pos    = s.frame_end ? 4'd0 : p;
    expected_samples.push_back(s);
  endtask

  always @(posedge clk) begin : track
    sample_t s;
    if (!rst_n) begin
      regs            = '0;
      regs.accel_gain = imuf_pkg::ACCEL_GAIN_RESET;
      regs.temp_recip = imuf_pkg::TEMP_RECIP_RESET;
      regs.temp_offset = imuf_pkg::TEMP_OFFSET_RESET;
      byte_pos        = '0;
      high_hold       = '0;
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          imuf_pkg::REG_ENABLE_MASK: begin
            regs.enable_mask = cfg_data[2:0];
            byte_pos         = '0;
          end
          imuf_pkg::REG_ACCEL_SCALE: regs.accel_scale = cfg_data[31:0];
          imuf_pkg::REG_GYRO_SCALE:  regs.gyro_scale  = cfg_data[31:0];
          imuf_pkg::REG_ACCEL_BIAS:  regs.accel_bias  = cfg_data[59:0];
          imuf_pkg::REG_ACCEL_GAIN:  regs.accel_gain  = cfg_data[59:0];
          imuf_pkg::REG_GYRO_BIAS:   regs.gyro_bias   = cfg_data[59:0];
          imuf_pkg::REG_TEMP_RECIP:  regs.temp_recip  = cfg_data[23:0];
          imuf_pkg::REG_TEMP_OFFSET: regs.temp_offset = cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) unpack_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample: channel %0d value %h last %0d",
                 out_tuser, out_tdata, out_tlast);
          errors++;
        end else begin
          s = expected_samples.pop_front();
          if (out_tuser !== s.channel) begin
            $error("channel: expected %0d, got %0d", s.channel, out_tuser);
            errors++;
          end
          if (out_tdata !== imuf_pkg::OUT_TDATA_W'(s.value)) begin
            $error("sample_value: expected %h, got %h", s.value, out_tdata);
            errors++;
          end
          if (out_tlast !== s.frame_end) begin
            $error("frame_end: expected %0d, got %0d", s.frame_end, out_tlast);
            errors++;
          end
          compared++;
        end
      end
    end
    mismatches       <= errors;
    samples_pending  <= expected_samples.size();
    samples_compared <= compared;
  end

endmodule

// ===== test/imu_fifo_frame_unpack_calibrate_tb.sv =====
// Testbench top for the IMU FIFO unpacker: stimulus, handshake idling and the verdict.
`timescale 1ns / 1ps

module imu_fifo_frame_unpack_calibrate_tb;

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int BYTE_TARGET   = 950;
  localparam logic [15:0] EDGE_WORDS [7] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                                             16'h8000, 16'h7FFF, 16'h0000};

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [7:0]                       in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [imuf_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [imuf_pkg::CH_W-1:0]        out_tuser;
  logic                             out_tlast;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [imuf_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [imuf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int bytes_sent = 0;
  int payload_bytes = 0;
  int settings_applied = 0;
  int stall_count = 0;
  int mismatches;
  int samples_pending;
  int samples_compared;

  always #4 clk = ~clk;

  imu_fifo_frame_unpack_calibrate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  imu_fifo_unpack_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .out_tlast        (out_tlast),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .samples_pending  (samples_pending),
    .samples_compared (samples_compared)
  );

  initial begin
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic send_byte(logic [7:0] b);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic write_reg(logic [imuf_pkg::CFG_IDX_W-1:0] idx,
                           logic [imuf_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (samples_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] pick_bias_field();
    case ($urandom_range(4))
      0: return 20'h7FFFF;
      1: return 20'h80000;
      2: return 20'h00000;
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] pick_gain_field();
    case ($urandom_range(4))
      0: return 20'h10000;
      1: return 20'hFFFFF;
      2: return 20'h00000;
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(4))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(32'h0010_0000);
    endcase
  endfunction

  function automatic logic [23:0] pick_recip();
    case ($urandom_range(4))
      0: return 24'h00_0000;
      1: return 24'hFF_FFFF;
      2: return imuf_pkg::TEMP_RECIP_RESET;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return imuf_pkg::TEMP_OFFSET_RESET;
      default: return $urandom;
    endcase
  endfunction

  function automatic int frame_bytes(logic [2:0] mask);
    return (mask[imuf_pkg::EN_ACCEL] ? int'(imuf_pkg::ACCEL_BYTES) : 0) +
           (mask[imuf_pkg::EN_GYRO]  ? int'(imuf_pkg::GYRO_BYTES)  : 0) +
           (mask[imuf_pkg::EN_TEMP]  ? int'(imuf_pkg::TEMP_BYTES)  : 0);
  endfunction

  task automatic apply_random_setting(bit need_data, output logic [2:0] mask);
    mask = (!need_data && $urandom_range(9) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
    write_reg(imuf_pkg::REG_ENABLE_MASK, {$urandom, 29'($urandom), mask});
    write_reg(imuf_pkg::REG_ACCEL_SCALE, {$urandom, pick_scale()});
    write_reg(imuf_pkg::REG_GYRO_SCALE,  {$urandom, pick_scale()});
    write_reg(imuf_pkg::REG_ACCEL_BIAS,  {4'($urandom), pick_bias_field(), pick_bias_field(),
                                          pick_bias_field()});
    write_reg(imuf_pkg::REG_ACCEL_GAIN,  {4'($urandom), pick_gain_field(), pick_gain_field(),
                                          pick_gain_field()});
    write_reg(imuf_pkg::REG_GYRO_BIAS,   {4'($urandom), pick_bias_field(), pick_bias_field(),
                                          pick_bias_field()});
    write_reg(imuf_pkg::REG_TEMP_RECIP,  {40'($urandom), pick_recip()});
    write_reg(imuf_pkg::REG_TEMP_OFFSET, {$urandom, pick_offset()});
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic run_random_phase(bit with_hold);
    logic [2:0] mask;
    int         size;
    int         count;
    apply_random_setting(with_hold, mask);
    size = frame_bytes(mask);
    if (size == 0) begin
      count = $urandom_range(2, 6);
    end else begin
      count = size * $urandom_range(1, 4);
      if ($urandom_range(3) == 0) count += $urandom_range(1, size - 1);
      if (with_hold) count += size * 4;
    end
    if (with_hold) hold_asked++;
    for (int k = 0; k < count; k++) send_byte(pick_byte());
    if (size != 0) payload_bytes += count;
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing enabled after reset: drop bytes
    send_byte(8'hA5);
    send_byte(8'h5A);
    wait_idle();

    write_reg(imuf_pkg::REG_ENABLE_MASK, 64'd7);
    write_reg(imuf_pkg::REG_ACCEL_SCALE, 64'hFFFF_FFFF);
    write_reg(imuf_pkg::REG_GYRO_SCALE,  64'hFFFF_FFFF);
    write_reg(imuf_pkg::REG_ACCEL_BIAS,  {4'h0, 20'h00001, 20'h80000, 20'h7FFFF});
    write_reg(imuf_pkg::REG_ACCEL_GAIN,  {4'h0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF});
    write_reg(imuf_pkg::REG_GYRO_BIAS,   {4'h0, 20'h00000, 20'h7FFFF, 20'h80000});
    write_reg(imuf_pkg::REG_TEMP_RECIP,  64'hFF_FFFF);
    write_reg(imuf_pkg::REG_TEMP_OFFSET, 64'h7FFF_FFFF);
    cfg_valid <= 1'b0;
    settings_applied++;
    foreach (EDGE_WORDS[i]) begin
      send_byte(EDGE_WORDS[i][15:8]);
      send_byte(EDGE_WORDS[i][7:0]);
    end
    wait_idle();

    // restart the frame mid-way by rewriting the enable mask
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h7F);
    wait_idle();
    write_reg(imuf_pkg::REG_ENABLE_MASK, 64'd6);
    cfg_valid <= 1'b0;
    settings_applied++;
    for (int k = 0; k < 6; k++) send_byte(pick_byte());
    wait_idle();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 16;
          rx_idle_pct = 50;
        end
        1: begin
          tx_idle_pct = 50;
          rx_idle_pct = 16;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      run_random_phase(1'b1);
      while (payload_bytes < BYTE_TARGET * (mode + 1) / 3) run_random_phase(1'b0);
    end

    $display("summary: %0d FIFO bytes under %0d register settings, %0d samples compared",
             bytes_sent, settings_applied, samples_compared);
    $display("summary: idling swapped between sender and receiver, %0d long output hold-offs",
             hold_served);
    if (mismatches == 0 && samples_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
